FILE: design/pta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pta_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH_DEFAULT = 16;
  localparam int ID_W                = 8;
  localparam int TIME_W              = 32;
  localparam int CFG_W               = 32;
  localparam int COUNT_OUT_W         = 5;

  // Configuration reset values
  localparam logic [ID_W-1:0]   SELF_RESET  = 8'd0;
  localparam logic [ID_W-1:0]   BCAST_RESET = 8'd255;
  localparam logic [TIME_W-1:0] STALE_RESET = 32'd30000;

  // Configuration register indexes
  localparam logic [1:0] REG_SELF  = 2'd0;
  localparam logic [1:0] REG_BCAST = 2'd1;
  localparam logic [1:0] REG_STALE = 2'd2;

  typedef enum logic [1:0] {
    OP_SEEN   = 2'd0,
    OP_SELECT = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BCAST   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

  // One stored table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Flags from the shared entry compare unit
  typedef struct packed {
    logic id_hit;
    logic self_hit;
    logic stale;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: design/pta_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module pta_mem #(
  parameter int DEPTH  = pta_pkg::TABLE_DEPTH_DEFAULT,
  parameter int ADDR_W = 4
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  waddr,
  input  wire pta_pkg::entry_t    wdata,
  input  wire logic [ADDR_W-1:0]  raddr,
  output pta_pkg::entry_t         rdata
);

  pta_pkg::entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/pta_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module pta_cmp (
  input  wire pta_pkg::entry_t                  entry,
  input  wire logic [pta_pkg::ID_W-1:0]         key_id,
  input  wire logic [pta_pkg::ID_W-1:0]         self_id,
  input  wire logic [pta_pkg::TIME_W-1:0]       now,
  input  wire logic [pta_pkg::TIME_W-1:0]       stale_limit,
  output pta_pkg::cmp_res_t                     res
);

  logic [pta_pkg::TIME_W-1:0] age;

  // Wrapped age, then the id and age checks
  always_comb begin
    age          = now - entry.stamp;
    res.id_hit   = (entry.id == key_id);
    res.self_hit = (entry.id == self_id);
    res.stale    = (age > stale_limit);
  end

endmodule

`default_nettype wire

FILE: design/peer_table_with_aging_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Peer table with aging: one word per start, one result word per item.
// Seen, select and sweep walk the table one entry per cycle through the entry
// memory and one shared compare unit; busy stays high through the walk and its
// finishing step, so a new word is taken only after the last. Clear skips the walk.
// Result ports hold until the next result; done marks each for a single cycle.
// rst is synchronous and restores the config registers and the table to entry 0
// holding self id 0.
module peer_table_with_aging_top #(
  parameter int TABLE_DEPTH = pta_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [pta_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        operation,
  input  wire logic [pta_pkg::ID_W-1:0]          device_id,
  input  wire logic [pta_pkg::TIME_W-1:0]        current_time,
  output logic                                   done,
  output logic [1:0]                             status,
  output logic [pta_pkg::ID_W-1:0]               active_id,
  output logic [pta_pkg::COUNT_OUT_W-1:0]        device_count,
  output logic                                   table_changed
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W   = COUNT_W + pta_pkg::COUNT_OUT_W;
  localparam logic [IDX_W-1:0]       LAST_IDX    = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [TABLE_DEPTH-1:0] VALID_FIRST = TABLE_DEPTH'(1);

  pta_pkg::state_t state, state_next;

  // Configuration
  logic [pta_pkg::ID_W-1:0]   self_id;
  logic [pta_pkg::ID_W-1:0]   broadcast_id;
  logic [pta_pkg::TIME_W-1:0] stale_limit;

  // Latched word
  pta_pkg::op_t               op_q;
  logic [pta_pkg::ID_W-1:0]   id_q;
  logic [pta_pkg::TIME_W-1:0] now_q;

  // Table state
  logic [TABLE_DEPTH-1:0]     valid;
  logic                       seed_live;
  logic [pta_pkg::ID_W-1:0]   active;

  // Walk state
  logic [IDX_W-1:0]           idx;
  logic                       eval_vld;
  logic [IDX_W-1:0]           eval_idx;
  logic                       hit_found;
  logic [IDX_W-1:0]           hit_idx;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;
  logic [COUNT_W-1:0]         acc_count;
  logic                       acc_changed;

  // Memory and compare
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  pta_pkg::entry_t            mem_wdata;
  pta_pkg::entry_t            mem_rdata;
  pta_pkg::entry_t            entry_rd;
  pta_pkg::cmp_res_t          cmp;
  logic                       cur_valid;
  logic                       freed;

  // Finish decisions
  pta_pkg::status_t           fin_status;
  logic                       fin_changed;
  logic [COUNT_W-1:0]         fin_count;

  // Result word
  pta_pkg::status_t           res_status;
  logic [pta_pkg::ID_W-1:0]   res_active;
  logic [COUNT_W-1:0]         res_count;
  logic                       res_changed;
  logic [EXT_W-1:0]           count_ext;

  logic                       accept;
  logic                       self_is_bcast;

  assign busy          = (state != pta_pkg::ST_IDLE);
  assign accept        = start && !busy;
  assign self_is_bcast = (self_id == broadcast_id);

  pta_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  // Entry 0 keeps its reset contents until first written or cleared
  assign entry_rd = (seed_live && eval_idx == '0)
                  ? pta_pkg::entry_t'{id: pta_pkg::SELF_RESET, stamp: '0}
                  : mem_rdata;

  pta_cmp u_cmp (
    .entry       (entry_rd),
    .key_id      (id_q),
    .self_id     (self_id),
    .now         (now_q),
    .stale_limit (stale_limit),
    .res         (cmp)
  );

  assign cur_valid = valid[eval_idx];
  assign freed     = cur_valid && !cmp.self_hit && cmp.stale;

  // Sequence the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pta_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pta_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (operation == pta_pkg::OP_CLEAR) ? pta_pkg::ST_FINISH
                                                       : pta_pkg::ST_SCAN;
        end
      end
      pta_pkg::ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = pta_pkg::ST_LAST;
        end
      end
      pta_pkg::ST_LAST:   state_next = pta_pkg::ST_FINISH;
      pta_pkg::ST_FINISH: state_next = pta_pkg::ST_IDLE;
      default:            state_next = pta_pkg::ST_IDLE;
    endcase
  end

  // Decide the outcome and the table write at the end of the walk
  always_comb begin
    fin_status  = pta_pkg::STAT_OK;
    fin_changed = acc_changed;
    fin_count   = acc_count;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx;
    mem_wdata   = pta_pkg::entry_t'{id: id_q, stamp: now_q};
    case (op_q)
      pta_pkg::OP_SEEN: begin
        if (id_q == broadcast_id) begin
          fin_status = pta_pkg::STAT_BCAST;
        end else if (hit_found) begin
          mem_we = (state == pta_pkg::ST_FINISH);
        end else if (free_found) begin
          mem_we      = (state == pta_pkg::ST_FINISH);
          mem_waddr   = free_idx;
          fin_changed = 1'b1;
          fin_count   = acc_count + COUNT_W'(1);
        end else begin
          fin_status = pta_pkg::STAT_FULL;
        end
      end
      pta_pkg::OP_SELECT: begin
        if (id_q != broadcast_id && !hit_found) begin
          fin_status = pta_pkg::STAT_UNKNOWN;
        end
      end
      pta_pkg::OP_SWEEP: begin
        fin_status = pta_pkg::STAT_OK;
      end
      pta_pkg::OP_CLEAR: begin
        fin_changed = 1'b1;
        mem_waddr   = '0;
        mem_wdata   = pta_pkg::entry_t'{id: self_id, stamp: now_q};
        if (self_is_bcast) begin
          fin_status = pta_pkg::STAT_BCAST;
          fin_count  = '0;
        end else begin
          mem_we    = (state == pta_pkg::ST_FINISH);
          fin_count = COUNT_W'(1);
        end
      end
      default: fin_status = pta_pkg::STAT_OK;
    endcase
  end

  // Control state: config, valid bits, walk bookkeeping, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      self_id      <= pta_pkg::SELF_RESET;
      broadcast_id <= pta_pkg::BCAST_RESET;
      stale_limit  <= pta_pkg::STALE_RESET;
      valid        <= VALID_FIRST;
      seed_live    <= 1'b1;
      active       <= pta_pkg::SELF_RESET;
      idx          <= '0;
      eval_vld     <= 1'b0;
      hit_found    <= 1'b0;
      free_found   <= 1'b0;
      acc_count    <= '0;
      acc_changed  <= 1'b0;
      done         <= 1'b0;
    end else begin
      done     <= (state == pta_pkg::ST_FINISH);
      eval_vld <= (state == pta_pkg::ST_SCAN);

      // Take register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          pta_pkg::REG_SELF:  self_id      <= cfg_data[pta_pkg::ID_W-1:0];
          pta_pkg::REG_BCAST: broadcast_id <= cfg_data[pta_pkg::ID_W-1:0];
          pta_pkg::REG_STALE: stale_limit  <= cfg_data[pta_pkg::TIME_W-1:0];
          default: ;
        endcase
      end

      // Start a new walk
      if (accept) begin
        idx         <= '0;
        hit_found   <= 1'b0;
        free_found  <= 1'b0;
        acc_count   <= '0;
        acc_changed <= 1'b0;
      end

      // Advance the read address
      if (state == pta_pkg::ST_SCAN && idx != LAST_IDX) begin
        idx <= idx + IDX_W'(1);
      end

      // Check one entry
      if (eval_vld) begin
        if (op_q == pta_pkg::OP_SWEEP) begin
          if (freed) begin
            valid[eval_idx] <= 1'b0;
            acc_changed     <= 1'b1;
          end
          acc_count <= acc_count + COUNT_W'(cur_valid && !freed);
        end else begin
          acc_count <= acc_count + COUNT_W'(cur_valid);
        end
        if (cur_valid && cmp.id_hit && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!cur_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end

      // Commit the operation
      if (state == pta_pkg::ST_FINISH) begin
        if ((mem_we && mem_waddr == '0) || op_q == pta_pkg::OP_CLEAR) begin
          seed_live <= 1'b0;
        end
        case (op_q)
          pta_pkg::OP_SEEN: begin
            if (id_q != broadcast_id && !hit_found && free_found) begin
              valid[free_idx] <= 1'b1;
            end
          end
          pta_pkg::OP_SELECT: begin
            if (id_q == broadcast_id || hit_found) begin
              active <= id_q;
            end
          end
          pta_pkg::OP_CLEAR: begin
            active <= self_id;
            valid  <= self_is_bcast ? '0 : VALID_FIRST;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload: latched word, entry positions, result word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= pta_pkg::op_t'(operation);
      id_q  <= device_id;
      now_q <= current_time;
    end
    eval_idx <= idx;
    if (eval_vld && cur_valid && cmp.id_hit && !hit_found) begin
      hit_idx <= eval_idx;
    end
    if (eval_vld && !cur_valid && !free_found) begin
      free_idx <= eval_idx;
    end
    if (state == pta_pkg::ST_FINISH) begin
      res_status  <= fin_status;
      res_count   <= fin_count;
      res_changed <= fin_changed;
      if (op_q == pta_pkg::OP_CLEAR) begin
        res_active <= self_id;
      end else if (op_q == pta_pkg::OP_SELECT &&
                   (id_q == broadcast_id || hit_found)) begin
        res_active <= id_q;
      end else begin
        res_active <= active;
      end
    end
  end

  // Drive the result ports
  assign count_ext     = EXT_W'(res_count);
  assign status        = res_status;
  assign active_id     = res_active;
  assign device_count  = count_ext[pta_pkg::COUNT_OUT_W-1:0];
  assign table_changed = res_changed;

  // Checks
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == pta_pkg::ST_FINISH))
    else $error("result strobe without a finishing step");

  a_no_check_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == pta_pkg::ST_IDLE) |-> !eval_vld)
    else $error("entry check pending while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (res_count <= COUNT_W'(TABLE_DEPTH)))
    else $error("device count exceeds table depth");

endmodule

`default_nettype wire

FILE: test/tb_peer_table_with_aging_top.sv
`timescale 1ns / 1ps

module tb_peer_table_with_aging_top;
  import pta_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RAND_PHASES     = 6;
  localparam int WORDS_PER_PHASE = 170;
  localparam logic [1:0] REG_NONE = 2'd3;

  // One result word as the block reports it
  typedef struct packed {
    status_t                  status;
    logic [ID_W-1:0]          active;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     changed;
  } outcome_t;

  // One row of the directed table: a register write or a command word
  typedef struct packed {
    logic                reg_wr;
    logic [1:0]          reg_sel;
    logic [CFG_W-1:0]    reg_val;
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   stamp;
    logic                typed;
    outcome_t            want;
  } step_row_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [1:0]               cfg_index = REG_SELF;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     start = 1'b0;
  logic [1:0]               operation = OP_SEEN;
  logic [ID_W-1:0]          device_id = '0;
  logic [TIME_W-1:0]        current_time = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic [ID_W-1:0]          active_id;
  logic [COUNT_OUT_W-1:0]   device_count;
  logic                     table_changed;

  // Shadow of the peer table and registers
  logic                     peer_valid [DEPTH];
  logic [ID_W-1:0]          peer_id [DEPTH];
  logic [TIME_W-1:0]        peer_stamp [DEPTH];
  logic [ID_W-1:0]          sel_id;
  logic [ID_W-1:0]          self_reg;
  logic [ID_W-1:0]          bcast_reg;
  logic [TIME_W-1:0]        stale_reg;

  outcome_t                 pending_results [$];
  step_row_t                directed_rows [$];
  outcome_t                 front_word;
  outcome_t                 blank_word = '0;
  int                       errors = 0;
  int                       cycle_count = 0;
  logic                     idle_on = 1'b1;
  int                       idle_odds = 30;

  peer_table_with_aging_top #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .operation(operation),
    .device_id(device_id),
    .current_time(current_time),
    .done(done),
    .status(status),
    .active_id(active_id),
    .device_count(device_count),
    .table_changed(table_changed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Restore the shadow to its post-reset contents
  function automatic void reset_shadow();
    for (int slot = 0; slot < DEPTH; slot++) begin
      peer_valid[slot] = 1'b0;
      peer_id[slot]    = '0;
      peer_stamp[slot] = '0;
    end
    peer_valid[0] = 1'b1;
    peer_id[0]    = SELF_RESET;
    self_reg      = SELF_RESET;
    bcast_reg     = BCAST_RESET;
    stale_reg     = STALE_RESET;
    sel_id        = SELF_RESET;
  endfunction

  // Refresh a known peer or take the lowest free slot
  function automatic status_t note_peer(input logic [ID_W-1:0] id,
                                        input logic [TIME_W-1:0] now,
                                        output logic added);
    added = 1'b0;
    if (id == bcast_reg) return STAT_BCAST;
    for (int slot = 0; slot < DEPTH; slot++) begin
      if (peer_valid[slot] && peer_id[slot] == id) begin
        peer_stamp[slot] = now;
        return STAT_OK;
      end
    end
    for (int slot = 0; slot < DEPTH; slot++) begin
      if (!peer_valid[slot]) begin
        peer_valid[slot] = 1'b1;
        peer_id[slot]    = id;
        peer_stamp[slot] = now;
        added            = 1'b1;
        return STAT_OK;
      end
    end
    return STAT_FULL;
  endfunction

  // Apply one command word to the shadow table and return its result word
  function automatic outcome_t predict_outcome(input op_t op,
                                               input logic [ID_W-1:0] id,
                                               input logic [TIME_W-1:0] now);
    outcome_t          res;
    logic              added;
    logic              known;
    logic [TIME_W-1:0] age;
    int                tally;
    res.status  = STAT_OK;
    res.changed = 1'b0;
    known       = 1'b0;
    tally       = 0;
    case (op)
      OP_SEEN: begin
        res.status  = note_peer(id, now, added);
        res.changed = added;
      end
      OP_SELECT: begin
        for (int slot = 0; slot < DEPTH; slot++)
          if (peer_valid[slot] && peer_id[slot] == id) known = 1'b1;
        if (id == bcast_reg || known) sel_id = id;
        else res.status = STAT_UNKNOWN;
      end
      OP_SWEEP: begin
        // age wraps modulo 2^32; self never expires
        for (int slot = 0; slot < DEPTH; slot++) begin
          age = now - peer_stamp[slot];
          if (peer_valid[slot] && peer_id[slot] != self_reg && age > stale_reg) begin
            peer_valid[slot] = 1'b0;
            res.changed      = 1'b1;
          end
        end
      end
      default: begin
        for (int slot = 0; slot < DEPTH; slot++) begin
          peer_valid[slot] = 1'b0;
          peer_id[slot]    = '0;
          peer_stamp[slot] = '0;
        end
        sel_id      = self_reg;
        res.status  = note_peer(self_reg, now, added);
        res.changed = 1'b1;
      end
    endcase
    for (int slot = 0; slot < DEPTH; slot++)
      if (peer_valid[slot]) tally++;
    res.count  = tally[COUNT_OUT_W-1:0];
    res.active = sel_id;
    return res;
  endfunction

  function automatic void add_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    step_row_t r;
    r         = '0;
    r.reg_wr  = 1'b1;
    r.reg_sel = idx;
    r.reg_val = val;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_word(input op_t op, input logic [ID_W-1:0] id,
                                   input logic [TIME_W-1:0] stamp);
    step_row_t r;
    r       = '0;
    r.op    = op;
    r.id    = id;
    r.stamp = stamp;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(input op_t op, input logic [ID_W-1:0] id,
                                      input logic [TIME_W-1:0] stamp, input status_t st,
                                      input logic [ID_W-1:0] act,
                                      input logic [COUNT_OUT_W-1:0] cnt, input logic chg);
    step_row_t r;
    r              = '0;
    r.op           = op;
    r.id           = id;
    r.stamp        = stamp;
    r.typed        = 1'b1;
    r.want.status  = st;
    r.want.active  = act;
    r.want.count   = cnt;
    r.want.changed = chg;
    directed_rows.push_back(r);
  endfunction

  // Present one word and hold it until accepted, then log its expected result
  task automatic send_word(input op_t op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] now, input logic typed,
                           input outcome_t want);
    outcome_t got;
    start        <= 1'b1;
    operation    <= op;
    device_id    <= id;
    current_time <= now;
    do begin
      @(posedge clk);
    end while (busy);
    got = predict_outcome(op, id, now);
    pending_results.push_back(typed ? want : got);
  endtask

  // Drop start for a random burst
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 99) < idle_odds) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding word has been answered
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SELF:  self_reg  = val[ID_W-1:0];
      REG_BCAST: bcast_reg = val[ID_W-1:0];
      REG_STALE: stale_reg = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d active_id %0d device_count %0d",
               status, active_id, device_count);
        errors++;
      end else begin
        front_word = pending_results.pop_front();
        if (status_t'(status) != front_word.status) begin
          $error("status: expected %0d, actual %0d", front_word.status, status);
          errors++;
        end
        if (active_id != front_word.active) begin
          $error("active_id: expected %0d, actual %0d", front_word.active, active_id);
          errors++;
        end
        if (device_count != front_word.count) begin
          $error("device_count: expected %0d, actual %0d", front_word.count, device_count);
          errors++;
        end
        if (table_changed != front_word.changed) begin
          $error("table_changed: expected %0d, actual %0d", front_word.changed,
                 table_changed);
          errors++;
        end
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    step_row_t           row;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   step_max;
    logic [CFG_W-1:0]    val;
    op_t                 op;
    int                  pick;

    reset_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: broadcast, refresh, add, select, stale boundary
    add_checked(OP_SEEN,   8'd255, 32'd0,     STAT_BCAST,   8'd0,   5'd1, 1'b0);
    add_checked(OP_SEEN,   8'd0,   32'd5,     STAT_OK,      8'd0,   5'd1, 1'b0);
    add_checked(OP_SEEN,   8'd1,   32'd10,    STAT_OK,      8'd0,   5'd2, 1'b1);
    add_checked(OP_SELECT, 8'd1,   32'd11,    STAT_OK,      8'd1,   5'd2, 1'b0);
    add_checked(OP_SELECT, 8'd200, 32'd12,    STAT_UNKNOWN, 8'd1,   5'd2, 1'b0);
    add_checked(OP_SELECT, 8'd255, 32'd13,    STAT_OK,      8'd255, 5'd2, 1'b0);
    add_checked(OP_SWEEP,  8'd0,   32'd30010, STAT_OK,      8'd255, 5'd2, 1'b0);
    add_checked(OP_SWEEP,  8'd0,   32'd30011, STAT_OK,      8'd255, 5'd1, 1'b1);
    // fill the table just below wrap, then overflow it
    for (int k = 1; k < DEPTH; k++) add_word(OP_SEEN, ID_W'(k), 32'hFFFF_FF00);
    add_checked(OP_SEEN,  ID_W'(DEPTH), 32'd20, STAT_FULL, 8'd255,
                COUNT_OUT_W'(DEPTH), 1'b0);
    // ages across the wrap stay small
    add_checked(OP_SWEEP, 8'd0, 32'd100, STAT_OK, 8'd255, COUNT_OUT_W'(DEPTH), 1'b0);
    // zero limit frees all but the new self
    add_reg(REG_SELF, 32'd5);
    add_reg(REG_STALE, 32'd0);
    add_checked(OP_SWEEP, 8'd0, 32'd100, STAT_OK, 8'd255, 5'd1, 1'b1);
    // self equal to broadcast leaves the cleared table empty
    add_reg(REG_BCAST, 32'd5);
    add_checked(OP_CLEAR,  8'd0,   32'hFFFF_FFFF, STAT_BCAST,   8'd5, 5'd0, 1'b1);
    add_checked(OP_SELECT, 8'd0,   32'd3,         STAT_UNKNOWN, 8'd5, 5'd0, 1'b0);
    add_checked(OP_SEEN,   8'd255, 32'd7,         STAT_OK,      8'd5, 5'd1, 1'b1);
    // largest limit never frees, even at the largest age
    add_reg(REG_BCAST, 32'd255);
    add_reg(REG_STALE, 32'hFFFF_FFFF);
    add_reg(REG_NONE, 32'h1234_5678);
    add_checked(OP_CLEAR,  8'd77, 32'd0, STAT_OK, 8'd5, 5'd1, 1'b1);
    add_checked(OP_SEEN,   8'd0,  32'd1, STAT_OK, 8'd5, 5'd2, 1'b1);
    add_checked(OP_SWEEP,  8'd0,  32'd0, STAT_OK, 8'd5, 5'd2, 1'b0);
    add_checked(OP_SELECT, 8'd0,  32'd2, STAT_OK, 8'd0, 5'd2, 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.reg_wr) begin
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        maybe_idle();
        send_word(row.op, row.id, row.stamp, row.typed, row.want);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_SELF, $urandom);
      val = $urandom;
      if ($urandom_range(0, 9) == 0) val[ID_W-1:0] = self_reg;
      write_reg(REG_BCAST, val);
      case (ph)
        0:       val = STALE_RESET;
        1:       val = 32'd0;
        2:       val = 32'd800;
        3:       val = 32'd4000;
        4:       val = $urandom;
        default: val = 32'hFFFF_FFFF;
      endcase
      write_reg(REG_STALE, val);
      if (ph == 2) write_reg(REG_NONE, $urandom);
      step_max  = (stale_reg > 32'd1_000_000) ? 32'hFFFF_FFFF : stale_reg / 8 + 64;
      now       = (ph == 3) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
      val       = $urandom;
      idle_on   = (ph < RAND_PHASES - 1);
      idle_odds = (ph == 1) ? 0 : 30;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if ($urandom_range(0, 199) == 0) drain();
        if ($urandom_range(0, 9) == 0) now = now + $urandom;
        else now = now + $urandom_range(0, step_max);
        // mostly a small id pool so the table fills and hits
        pick = $urandom_range(0, 99);
        if (pick < 80)      id = val[ID_W-1:0] + ID_W'($urandom_range(0, 22));
        else if (pick < 90) id = self_reg;
        else if (pick < 95) id = bcast_reg;
        else                id = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 55)      op = OP_SEEN;
        else if (pick < 75) op = OP_SELECT;
        else if (pick < 98) op = OP_SWEEP;
        else                op = OP_CLEAR;
        maybe_idle();
        send_word(op, id, now, 1'b0, blank_word);
      end
    end

    drain();
    repeat (DEPTH + 5) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pta_pkg.sv
design/pta_mem.sv
design/pta_cmp.sv
design/peer_table_with_aging_top.sv
test/tb_peer_table_with_aging_top.sv
